// File: rtl/core/mau_pkg.sv
package mau_pkg;

    localparam int RES_W  = 31;
    localparam int WIDE_W = 64;
    localparam int PROD_W = 2 * RES_W;
    localparam int CNT_W  = $clog2(WIDE_W + 1);

    localparam logic [RES_W-1:0] MOD_RESET = RES_W'(998244353);

    typedef enum logic [2:0] {
        FN_REDUCE = 3'd0,
        FN_ADD    = 3'd1,
        FN_SUB    = 3'd2,
        FN_NEG    = 3'd3,
        FN_MUL    = 3'd4,
        FN_DIV    = 3'd5,
        FN_POW    = 3'd6,
        FN_INV    = 3'd7
    } func_t;

endpackage

// File: rtl/core/modular_arithmetic_unit.sv
// Modular arithmetic unit: one residue result per request, modulo a configured modulus.
// Channels: request in (in_valid / in_stall, fields func, operand_a, operand_b,
// wide_value), result out (out_valid / out_stall, fields result, is_zero), and a
// config write channel (cfg_valid / cfg_ready, cfg_data) that sets the modulus.
// cfg_ready and the request side are open only while the unit is idle.
// All reduction runs on one shared reducer that retires one dividend bit per cycle,
// fed by a single 31x31 multiplier; a small sequencer chains the steps.
// Each request first reduces both operands, then
//   add, sub, negate: finish directly; reduce wide value: reduce the 64-bit value;
//   multiply: multiply, then reduce the product; power: up to 2 multiply steps per exponent bit;
//   inverse: up to 60 multiply steps;
//   negative power: inverse plus up to 125 multiply steps.
// A modulus below 2 returns 0 without any reduction.
// One request is in flight at a time; the next is taken once the result is in
// the output register, even while the receiver still stalls it.
// A stalled result holds; the unit waits to finish the next request until the
// output register is free.
// Reset clears the output valid, returns to idle and loads the modulus 998244353.
module modular_arithmetic_unit
    import mau_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [2:0]              func,
    input  logic [RES_W-1:0]        operand_a,
    input  logic [RES_W-1:0]        operand_b,
    input  logic signed [WIDE_W-1:0] wide_value,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [RES_W-1:0]        result,
    output logic                    is_zero,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [RES_W-1:0]        cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_DISP,
        S_PCHK,
        S_PSQ,
        S_PDONE,
        S_FIN
    } state_t;

    typedef enum logic [2:0] {
        D_A,
        D_B,
        D_WIDE,
        D_ACC,
        D_BASE,
        D_FINAL
    } dest_t;

    state_t              state_reg, state_next;
    dest_t               dest_reg, dest_next;
    func_t               func_reg, func_next;
    logic [RES_W-1:0]    modulus_reg, modulus_next;
    logic [RES_W-1:0]    a_reg, a_next;
    logic [RES_W-1:0]    b_reg, b_next;
    logic                neg_reg, neg_next;
    logic                second_reg, second_next;
    logic [WIDE_W-1:0]   mag_reg, mag_next;
    logic [RES_W-1:0]    acc_reg, acc_next;
    logic [RES_W-1:0]    base_reg, base_next;
    logic [WIDE_W-1:0]   exp_reg, exp_next;
    logic [WIDE_W-1:0]   red_reg, red_next;
    logic [RES_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [RES_W-1:0]    res_reg, res_next;
    logic [RES_W-1:0]    result_reg, result_next;
    logic                out_valid_reg, out_valid_next;

    logic [RES_W:0]      trial;
    logic [RES_W:0]      trial_diff;
    logic [RES_W-1:0]    rem_step;
    logic                mul_go;
    logic [RES_W-1:0]    mul_x;
    logic [RES_W-1:0]    mul_y;
    dest_t               mul_dest;
    logic [PROD_W-1:0]   prod;
    logic                pow_go;
    logic [RES_W-1:0]    pow_base;
    logic [WIDE_W-1:0]   pow_exp;
    logic                inv_go;
    logic [RES_W-1:0]    inv_x;
    logic [RES_W:0]      sum;
    logic [RES_W:0]      sum_red;
    logic                accept;

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign is_zero   = (result_reg == '0);

    // one restoring step of the shared reducer
    assign trial      = {rem_reg, red_reg[WIDE_W-1]};
    assign trial_diff = trial - {1'b0, modulus_reg};
    assign rem_step   = trial_diff[RES_W] ? trial[RES_W-1:0] : trial_diff[RES_W-1:0];

    assign prod = mul_x * mul_y;

    always_comb
    begin
        state_next     = state_reg;
        dest_next      = dest_reg;
        func_next      = func_reg;
        modulus_next   = modulus_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        neg_next       = neg_reg;
        second_next    = second_reg;
        mag_next       = mag_reg;
        acc_next       = acc_reg;
        base_next      = base_reg;
        exp_next       = exp_reg;
        red_next       = red_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        mul_go         = 1'b0;
        mul_x          = '0;
        mul_y          = '0;
        mul_dest       = D_FINAL;
        pow_go         = 1'b0;
        pow_base       = '0;
        pow_exp        = '0;
        inv_go         = 1'b0;
        inv_x          = '0;
        sum            = '0;
        sum_red        = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            modulus_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next   = func_t'(func);
                    b_next      = operand_b;
                    neg_next    = wide_value[WIDE_W-1];
                    mag_next    = wide_value[WIDE_W-1] ? (WIDE_W'(0) - wide_value) : wide_value;
                    second_next = 1'b0;
                    if (modulus_reg < RES_W'(2))
                    begin
                        res_next   = '0;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        red_next   = {operand_a, {(WIDE_W-RES_W){1'b0}}};
                        rem_next   = '0;
                        cnt_next   = CNT_W'(RES_W);
                        dest_next  = D_A;
                        state_next = S_RED;
                    end
                end
            end

            S_RED:
            begin
                rem_next = rem_step;
                red_next = {red_reg[WIDE_W-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    case (dest_reg)
                        D_A:
                        begin
                            a_next    = rem_step;
                            red_next  = {b_reg, {(WIDE_W-RES_W){1'b0}}};
                            rem_next  = '0;
                            cnt_next  = CNT_W'(RES_W);
                            dest_next = D_B;
                        end
                        D_B:
                        begin
                            b_next     = rem_step;
                            state_next = S_DISP;
                        end
                        D_WIDE:
                        begin
                            res_next   = (neg_reg && rem_step != '0) ?
                                         (modulus_reg - rem_step) : rem_step;
                            state_next = S_FIN;
                        end
                        D_ACC:
                        begin
                            acc_next   = rem_step;
                            state_next = S_PSQ;
                        end
                        D_BASE:
                        begin
                            base_next  = rem_step;
                            exp_next   = exp_reg >> 1;
                            state_next = S_PCHK;
                        end
                        default:
                        begin
                            res_next   = rem_step;
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            S_DISP:
            begin
                case (func_reg)
                    FN_REDUCE:
                    begin
                        red_next   = mag_reg;
                        rem_next   = '0;
                        cnt_next   = CNT_W'(WIDE_W);
                        dest_next  = D_WIDE;
                        state_next = S_RED;
                    end
                    FN_ADD:
                    begin
                        sum        = {1'b0, a_reg} + {1'b0, b_reg};
                        sum_red    = sum - {1'b0, modulus_reg};
                        res_next   = sum_red[RES_W] ? sum[RES_W-1:0] : sum_red[RES_W-1:0];
                        state_next = S_FIN;
                    end
                    FN_SUB:
                    begin
                        sum        = {1'b0, a_reg} - {1'b0, b_reg};
                        sum_red    = sum + {1'b0, modulus_reg};
                        res_next   = sum[RES_W] ? sum_red[RES_W-1:0] : sum[RES_W-1:0];
                        state_next = S_FIN;
                    end
                    FN_NEG:
                    begin
                        res_next   = (a_reg == '0) ? '0 : (modulus_reg - a_reg);
                        state_next = S_FIN;
                    end
                    FN_MUL:
                    begin
                        mul_go   = 1'b1;
                        mul_x    = a_reg;
                        mul_y    = b_reg;
                        mul_dest = D_FINAL;
                    end
                    FN_DIV:
                    begin
                        inv_go = 1'b1;
                        inv_x  = b_reg;
                    end
                    FN_POW:
                    begin
                        if (neg_reg)
                        begin
                            inv_go = 1'b1;
                            inv_x  = a_reg;
                        end
                        else
                        begin
                            pow_go   = 1'b1;
                            pow_base = a_reg;
                            pow_exp  = mag_reg;
                        end
                    end
                    default:
                    begin
                        inv_go = 1'b1;
                        inv_x  = a_reg;
                    end
                endcase
            end

            S_PCHK:
            begin
                if (exp_reg == '0)
                begin
                    state_next = S_PDONE;
                end
                else if (exp_reg[0])
                begin
                    mul_go   = 1'b1;
                    mul_x    = acc_reg;
                    mul_y    = base_reg;
                    mul_dest = D_ACC;
                end
                else
                begin
                    state_next = S_PSQ;
                end
            end

            S_PSQ:
            begin
                // drop the last squaring, its value is never used
                if (exp_reg[WIDE_W-1:1] == '0)
                begin
                    state_next = S_PDONE;
                end
                else
                begin
                    mul_go   = 1'b1;
                    mul_x    = base_reg;
                    mul_y    = base_reg;
                    mul_dest = D_BASE;
                end
            end

            S_PDONE:
            begin
                if (func_reg == FN_DIV)
                begin
                    mul_go   = 1'b1;
                    mul_x    = a_reg;
                    mul_y    = acc_reg;
                    mul_dest = D_FINAL;
                end
                else if (func_reg == FN_POW && neg_reg && !second_reg)
                begin
                    second_next = 1'b1;
                    pow_go      = 1'b1;
                    pow_base    = acc_reg;
                    pow_exp     = mag_reg;
                end
                else
                begin
                    res_next   = acc_reg;
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    result_next    = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // inverse by Fermat, zero maps to zero
        if (inv_go)
        begin
            if (inv_x == '0)
            begin
                acc_next   = '0;
                state_next = S_PDONE;
            end
            else
            begin
                pow_go   = 1'b1;
                pow_base = inv_x;
                pow_exp  = WIDE_W'(modulus_reg) - WIDE_W'(2);
            end
        end

        if (pow_go)
        begin
            base_next  = pow_base;
            acc_next   = RES_W'(1);
            exp_next   = pow_exp;
            state_next = S_PCHK;
        end

        if (mul_go)
        begin
            red_next   = {prod, {(WIDE_W-PROD_W){1'b0}}};
            rem_next   = '0;
            cnt_next   = CNT_W'(PROD_W);
            dest_next  = mul_dest;
            state_next = S_RED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            modulus_reg   <= MOD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            modulus_reg   <= modulus_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dest_reg   <= dest_next;
        func_reg   <= func_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        neg_reg    <= neg_next;
        second_reg <= second_next;
        mag_reg    <= mag_next;
        acc_reg    <= acc_next;
        base_reg   <= base_next;
        exp_reg    <= exp_next;
        red_reg    <= red_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        res_reg    <= res_next;
        result_reg <= result_next;
    end

endmodule
